// File: design/fpr_pkg.sv
// shared types, codes and the crc byte update of the framed packet receiver
package fpr_pkg;

  // report codes carried on the event field
  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_ACCEPTED   = 2'd1,
    EV_CRC_ERROR  = 2'd2,
    EV_INCOMPLETE = 2'd3
  } evt_code_t;

  // configuration register indexes
  localparam logic [1:0] CFG_CRC_POLY     = 2'd0;
  localparam logic [1:0] CFG_START_MARKER = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH   = 2'd2;

  localparam logic [15:0] CRC_POLY_RESET     = 16'h1021;
  localparam logic [7:0]  START_MARKER_RESET = 8'hAA;
  localparam logic [7:0]  MAX_LENGTH_RESET   = 8'hFF;

  // assembled packet header
  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] chunk_idx;
    logic [15:0] chunk_total;
    logic [15:0] sequence_number;
    logic [7:0]  kind;
    logic [31:0] time_stamp;
    logic [7:0]  length;
  } hdr_t;

  // one result word on its way to the output
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        check;        // verdict still to be decided from crc
    evt_code_t   evt;
    hdr_t        hdr;
    logic [15:0] crc;
    logic [1:0]  port;
  } rec_t;

  // augmented msb-first crc-16: shift in one byte, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] poly,
                                           input logic [15:0] crc,
                                           input logic [7:0]  data);
    logic [16:0] r;
    logic [15:0] c;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      r = {c, data[k]};
      c = r[16] ? (r[15:0] ^ poly) : r[15:0];
    end
    return c;
  endfunction

endpackage

// File: design/fpr_parser.sv
// frame parser: marker hunt, header assembly, payload count and crc over the frame
module fpr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_chunk_end,
  input  logic [1:0]      in_port_id,
  input  logic [15:0]     crc_poly,
  input  logic [7:0]      start_marker,
  input  logic [7:0]      max_length,
  output logic            rec_valid,
  input  logic            rec_stall,
  output fpr_pkg::rec_t   rec
);
  import fpr_pkg::*;

  typedef enum logic [4:0] {
    PH_SOH1, PH_SOH2, PH_CK1, PH_CK2, PH_CN1, PH_CN2, PH_CT1, PH_CT2,
    PH_SQ1, PH_SQ2, PH_KIND, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_LEN, PH_PAY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  rem_r, rem_nxt;
  hdr_t        hdr_r, hdr_nxt, hdr_new;
  logic        rec_valid_r, rec_valid_nxt;
  rec_t        rec_r, rec_nxt;
  logic        accept;
  logic        verdict, incomplete, is_payload, has_result;
  phase_t      phase_step;

  assign in_stall  = rec_valid_r && rec_stall;
  assign accept    = in_valid && !in_stall;
  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  // next state for one byte
  always_comb begin
    phase_step = phase_r;
    rem_nxt    = rem_r;
    hdr_new    = hdr_r;
    is_payload = 1'b0;
    verdict    = 1'b0;
    // crc restarts at the first chunk number byte
    crc_nxt    = crc_feed(crc_poly, (phase_r == PH_CN1) ? 16'h0000 : crc_r, in_data_byte);
    unique case (phase_r)
      PH_SOH1: begin
        rem_nxt = 8'd0;
        if (in_data_byte == start_marker) phase_step = PH_SOH2;
      end
      PH_SOH2: phase_step = (in_data_byte == start_marker) ? PH_CK1 : PH_SOH1;
      PH_CK1: begin
        hdr_new.checksum = {8'd0, in_data_byte};
        phase_step = PH_CK2;
      end
      PH_CK2: begin
        hdr_new.checksum = {hdr_r.checksum[7:0], in_data_byte};
        phase_step = PH_CN1;
      end
      PH_CN1: begin
        hdr_new.chunk_idx = {8'd0, in_data_byte};
        phase_step = PH_CN2;
      end
      PH_CN2: begin
        hdr_new.chunk_idx = {hdr_r.chunk_idx[7:0], in_data_byte};
        phase_step = PH_CT1;
      end
      PH_CT1: begin
        hdr_new.chunk_total = {8'd0, in_data_byte};
        phase_step = PH_CT2;
      end
      PH_CT2: begin
        hdr_new.chunk_total = {hdr_r.chunk_total[7:0], in_data_byte};
        phase_step = PH_SQ1;
      end
      PH_SQ1: begin
        hdr_new.sequence_number = {8'd0, in_data_byte};
        phase_step = PH_SQ2;
      end
      PH_SQ2: begin
        hdr_new.sequence_number = {hdr_r.sequence_number[7:0], in_data_byte};
        phase_step = PH_KIND;
      end
      PH_KIND: begin
        hdr_new.kind = in_data_byte;
        phase_step = PH_TS1;
      end
      PH_TS1: begin
        hdr_new.time_stamp = {24'd0, in_data_byte};
        phase_step = PH_TS2;
      end
      PH_TS2, PH_TS3, PH_TS4: begin
        hdr_new.time_stamp = {hdr_r.time_stamp[23:0], in_data_byte};
        phase_step = (phase_r == PH_TS4) ? PH_LEN : phase_t'(phase_r + 5'd1);
      end
      PH_LEN: begin
        hdr_new.length = in_data_byte;
        rem_nxt = in_data_byte;
        if (in_data_byte > max_length) begin
          phase_step = PH_SOH1;
        end else if (in_data_byte == 8'd0) begin
          verdict = 1'b1;
          phase_step = PH_SOH1;
        end else begin
          phase_step = PH_PAY;
        end
      end
      PH_PAY: begin
        is_payload = 1'b1;
        rem_nxt = rem_r - 8'd1;
        if (rem_nxt == 8'd0) begin
          verdict = 1'b1;
          phase_step = PH_SOH1;
        end
      end
      default: phase_step = PH_SOH1;
    endcase

    // chunk ended while a frame is still open
    incomplete = in_chunk_end && (phase_step != PH_SOH1);
    has_result = is_payload || verdict || incomplete;
    phase_nxt  = incomplete ? PH_SOH1 : phase_step;
    hdr_nxt    = (verdict || incomplete) ? '0 : hdr_new;

    // result word
    rec_nxt.payload_valid = is_payload;
    rec_nxt.payload_byte  = is_payload ? in_data_byte : 8'd0;
    rec_nxt.check         = verdict;
    rec_nxt.evt           = incomplete ? EV_INCOMPLETE : EV_NONE;
    rec_nxt.hdr           = (verdict || incomplete) ? hdr_new : '0;
    rec_nxt.crc           = crc_nxt;
    rec_nxt.port          = (verdict || incomplete) ? in_port_id : 2'd0;

    // result register occupancy
    if (accept) begin
      rec_valid_nxt = has_result;
    end else if (!rec_stall) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  // state, control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SOH1;
      crc_r       <= 16'h0000;
      rem_r       <= 8'd0;
      hdr_r       <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        crc_r   <= crc_nxt;
        rem_r   <= rem_nxt;
        hdr_r   <= hdr_nxt;
      end
    end
    if (accept) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

// File: design/fpr_verdict.sv
// verdict pipeline: crc finish with two zero bytes, checksum compare, output register
module fpr_verdict (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rec_valid,
  output logic            rec_stall,
  input  fpr_pkg::rec_t   rec,
  input  logic [15:0]     crc_poly,
  output logic            out_valid,
  input  logic            out_stall,
  output fpr_pkg::rec_t   out_rec
);
  import fpr_pkg::*;

  logic  mid_valid_r, out_valid_r;
  rec_t  mid_r, mid_nxt, out_r, out_nxt;
  logic  out_ready, mid_ready;
  logic [15:0] crc_final;

  assign out_ready = !out_valid_r || !out_stall;
  assign mid_ready = !mid_valid_r || out_ready;
  assign rec_stall = !mid_ready;
  assign out_valid = out_valid_r;
  assign out_rec   = out_r;

  // first zero byte, then second zero byte and compare
  always_comb begin
    mid_nxt     = rec;
    mid_nxt.crc = crc_feed(crc_poly, rec.crc, 8'd0);
    crc_final   = crc_feed(crc_poly, mid_r.crc, 8'd0);
    out_nxt     = mid_r;
    if (mid_r.check) begin
      out_nxt.evt = (crc_final == mid_r.hdr.checksum) ? EV_ACCEPTED : EV_CRC_ERROR;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mid_ready) mid_valid_r <= rec_valid;
      if (out_ready) out_valid_r <= mid_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (mid_ready && rec_valid) mid_r <= mid_nxt;
    if (out_ready && mid_valid_r) out_r <= out_nxt;
  end

endmodule

// File: design/framed_packet_receiver_crc16.sv
// top level of the framed packet receiver: configuration registers and the two parts
// Takes one received byte per cycle and returns at most one result word per byte:
// a payload byte passed through, a frame verdict (accepted or checksum error) or an
// incomplete-frame report when a chunk ends inside a frame. A byte goes through three
// registers (parser result, first crc finishing byte, output register) on its way to the
// outputs; a new byte is taken every cycle unless out_stall holds the output and the
// pipeline behind it is full. The crc byte update is one combinational step per stage.
// There is no clearing pass after reset.
module framed_packet_receiver_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // received bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_end,
  input  logic [1:0]  in_port_id,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_event_res,
  output logic [15:0] out_chunk_idx,
  output logic [15:0] out_chunk_total,
  output logic [15:0] out_sequence_number,
  output logic [7:0]  out_packet_kind,
  output logic [31:0] out_time_stamp,
  output logic [7:0]  out_pay_len,
  output logic [15:0] out_received_checksum,
  output logic [1:0]  out_source_port
);
  import fpr_pkg::*;

  logic [15:0] crc_poly_r;
  logic [7:0]  start_marker_r;
  logic [7:0]  max_length_r;
  logic        rec_valid, rec_stall;
  rec_t        rec, out_rec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r     <= CRC_POLY_RESET;
      start_marker_r <= START_MARKER_RESET;
      max_length_r   <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CRC_POLY:     crc_poly_r     <= cfg_data;
        CFG_START_MARKER: start_marker_r <= cfg_data[7:0];
        CFG_MAX_LENGTH:   max_length_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fpr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_chunk_end (in_chunk_end),
    .in_port_id   (in_port_id),
    .crc_poly     (crc_poly_r),
    .start_marker (start_marker_r),
    .max_length   (max_length_r),
    .rec_valid    (rec_valid),
    .rec_stall    (rec_stall),
    .rec          (rec)
  );

  fpr_verdict u_verdict (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .crc_poly  (crc_poly_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (out_rec)
  );

  // result word onto the ports
  assign out_payload_valid     = out_rec.payload_valid;
  assign out_payload_byte      = out_rec.payload_byte;
  assign out_event_res         = out_rec.evt;
  assign out_chunk_idx         = out_rec.hdr.chunk_idx;
  assign out_chunk_total       = out_rec.hdr.chunk_total;
  assign out_sequence_number   = out_rec.hdr.sequence_number;
  assign out_packet_kind       = out_rec.hdr.kind;
  assign out_time_stamp        = out_rec.hdr.time_stamp;
  assign out_pay_len           = out_rec.hdr.length;
  assign out_received_checksum = out_rec.hdr.checksum;
  assign out_source_port       = out_rec.port;

endmodule
